>>> design/sirt_pkg.sv
// Shared types and constants for the signed integer to radix text core.
// No dependencies; used by every module of the core.
`default_nettype none

package sirt_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 4;   // digit values 0..15
  localparam int unsigned NUM_SYMS = 16;
  localparam int unsigned RADIX_W  = 5;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] SYM_MINUS = 8'd45;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // one classified number on its way to the conversion engine
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

endpackage

`default_nettype wire

>>> design/sirt_front.sv
// Front end: takes start/value, checks the configured digit set and forms sign and
// magnitude. Depends on sirt_pkg.
`default_nettype none

module sirt_front #(
  parameter int MAX_BASE = 16
) (
  input  wire logic                                       start,
  input  wire logic signed [sirt_pkg::VALUE_W-1:0]        value,
  input  wire logic        [sirt_pkg::RADIX_W-1:0]        base_length,
  input  wire logic        [2*sirt_pkg::CFG_W-1:0]        symbols,
  input  wire logic                                       q_full,
  output logic                                            busy,
  output logic                                            push,
  output sirt_pkg::item_t                                 item
);

  logic                             base_ok;
  logic [sirt_pkg::CHAR_W-1:0]      sym_i;
  logic [sirt_pkg::VALUE_W-1:0]     v;

  // all pairwise compares in parallel, gated by the radix
  always_comb begin
    base_ok = (base_length >= sirt_pkg::RADIX_W'(2)) &&
              (base_length <= sirt_pkg::RADIX_W'(MAX_BASE));
    for (int i = 0; i < sirt_pkg::NUM_SYMS; i++) begin
      sym_i = symbols[i*sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W];
      if (sirt_pkg::RADIX_W'(i) < base_length) begin
        if (sym_i == '0 || sym_i == sirt_pkg::SYM_PLUS || sym_i == sirt_pkg::SYM_MINUS)
          base_ok = 1'b0;
        for (int j = i + 1; j < sirt_pkg::NUM_SYMS; j++) begin
          if (sirt_pkg::RADIX_W'(j) < base_length &&
              symbols[j*sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W] == sym_i)
            base_ok = 1'b0;
        end
      end
    end
  end

  assign busy     = q_full;
  assign v        = value;
  assign item.neg = v[sirt_pkg::VALUE_W-1];
  assign item.mag = v[sirt_pkg::VALUE_W-1] ? (~v + sirt_pkg::VALUE_W'(1)) : v;
  // bad digit set: item is taken and dropped
  assign push     = start && !q_full && base_ok;

endmodule

`default_nettype wire

>>> design/sirt_queue.sv
// Two-entry queue between front end and conversion engine.
// Depends on sirt_pkg for the entry type.
`default_nettype none

module sirt_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sirt_pkg::item_t wr_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 valid,
  output sirt_pkg::item_t      rd_item
);

  sirt_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= wr_item;
        wr_ptr          <= ~wr_ptr;
      end
      if (pop)
        rd_ptr <= ~rd_ptr;
      if (push && !pop)
        count <= count + 2'd1;
      else if (pop && !push)
        count <= count - 2'd1;
    end
  end

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign rd_item = entries[rd_ptr];

endmodule

`default_nettype wire

>>> design/sirt_back.sv
// Conversion engine: repeated division by the radix, 8 quotient bits per cycle,
// digits stacked and then sent out most significant first. Depends on sirt_pkg.
`default_nettype none

module sirt_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire sirt_pkg::item_t                   q_item,
  input  wire logic [sirt_pkg::RADIX_W-1:0]      base_length,
  input  wire logic [2*sirt_pkg::CFG_W-1:0]      symbols,
  output logic                                   pop,
  output logic                                   strobe,
  output logic [sirt_pkg::CHAR_W-1:0]            character,
  output logic                                   last
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT} state_t;

  state_t                         state;
  logic                           neg;
  logic [sirt_pkg::VALUE_W-1:0]   quot;
  logic [sirt_pkg::DIGIT_W-1:0]   rem;
  logic [1:0]                     step;       // byte of the dividend in progress
  logic [5:0]                     nd;         // digits on the stack, 0..32
  logic [sirt_pkg::DIGIT_W-1:0]   stack [32];

  logic [sirt_pkg::RADIX_W-1:0]   r;
  logic [7:0]                     qbyte;
  logic [sirt_pkg::VALUE_W-1:0]   quot_next;
  logic [4:0]                     top;
  logic [sirt_pkg::DIGIT_W-1:0]   top_digit;

  // one byte of long division; partial remainder stays below the radix
  always_comb begin
    r     = {1'b0, rem};
    qbyte = '0;
    for (int b = 7; b >= 0; b--) begin
      r = {r[sirt_pkg::DIGIT_W-1:0], quot[24+b]};
      if (r >= base_length) begin
        r        = r - base_length;
        qbyte[b] = 1'b1;
      end
    end
  end

  assign quot_next = {quot[23:0], qbyte};
  assign top       = 5'(nd - 6'd1);
  assign top_digit = stack[top];
  assign pop       = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      nd     <= '0;
      step   <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            neg   <= q_item.neg;
            quot  <= q_item.mag;
            rem   <= '0;
            step  <= '0;
            nd    <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          quot <= quot_next;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            stack[nd[4:0]] <= r[sirt_pkg::DIGIT_W-1:0];
            nd             <= nd + 6'd1;
            rem            <= '0;
            if (quot_next == '0)
              state <= neg ? S_SIGN : S_EMIT;
          end else begin
            rem <= r[sirt_pkg::DIGIT_W-1:0];
          end
        end
        S_SIGN: begin
          strobe    <= 1'b1;
          character <= sirt_pkg::SYM_MINUS;
          last      <= 1'b0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          strobe    <= 1'b1;
          character <= symbols[top_digit*sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W];
          last      <= (nd == 6'd1);
          nd        <= nd - 6'd1;
          if (nd == 6'd1)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/signed_int_to_custom_radix_text_core.sv
// Top level: configuration registers, front end, queue and conversion engine.
// Depends on sirt_pkg, sirt_front, sirt_queue, sirt_back.
//
//  channel   | ports                          | transfer when
//  ----------+--------------------------------+----------------------------
//  input     | start, busy, value             | start && !busy at clk edge
//  result    | strobe, character, last        | every cycle strobe is high
//  config    | cfg_we, cfg_index, cfg_data    | cfg_we at clk edge
//
// Timing: for each digit the divider works through the dividend one byte per
// cycle, four bytes per digit; then each character (minus sign included) is
// sent out, after the queue and hand-off. The worst case is radix 2 and the
// most negative value.
// busy rises only when the two-entry queue is full, so up to two numbers wait
// while one converts. An invalid digit set drops the number with no output.
// rst is synchronous and clears control state and all configuration registers.
// Results cannot be stalled: each character is on the ports for one cycle.
`default_nettype none

module signed_int_to_custom_radix_text_core #(
  parameter int MAX_BASE = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input command
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [sirt_pkg::VALUE_W-1:0]   value,
  // configuration writes
  input  wire logic                                  cfg_we,
  input  wire logic        [sirt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [sirt_pkg::CFG_W-1:0]     cfg_data,
  // result characters
  output logic                                       strobe,
  output logic             [sirt_pkg::CHAR_W-1:0]    character,
  output logic                                       last
);

  // configuration registers
  logic [sirt_pkg::RADIX_W-1:0]  base_length;
  logic [sirt_pkg::CFG_W-1:0]    symbols_low;
  logic [sirt_pkg::CFG_W-1:0]    symbols_high;
  logic [2*sirt_pkg::CFG_W-1:0]  symbols;

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;
  sirt_pkg::item_t wr_item;
  sirt_pkg::item_t rd_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sirt_pkg::REG_BASE_LENGTH:  base_length  <= cfg_data[sirt_pkg::RADIX_W-1:0];
        sirt_pkg::REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        sirt_pkg::REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  // symbol k sits in byte k
  assign symbols = {symbols_high, symbols_low};

  sirt_front #(
    .MAX_BASE(MAX_BASE)
  ) u_front (
    .start       (start),
    .value       (value),
    .base_length (base_length),
    .symbols     (symbols),
    .q_full      (q_full),
    .busy        (busy),
    .push        (push),
    .item        (wr_item)
  );

  sirt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .full    (q_full),
    .valid   (q_valid),
    .rd_item (rd_item)
  );

  sirt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (rd_item),
    .base_length (base_length),
    .symbols     (symbols),
    .pop         (pop),
    .strobe      (strobe),
    .character   (character),
    .last        (last)
  );

endmodule

`default_nettype wire
